[rtl/lpbt_pkg.sv]
package lpbt_pkg;

   // default geometry of the page table
   localparam int LPBT_ENTRIES    = 16;
   localparam int LPBT_ADDR_BITS  = 32;
   localparam int LPBT_STAMP_BITS = 32;

   // page address as it travels on the request and response buses
   localparam int PAGE_BITS = 32;

   // resident limit register
   localparam int                   LIMIT_BITS  = 4;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd8;

   // access kinds carried in req_tuser
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // response tdata layout, lowest bit first
   localparam int RSP_HIT_POS     = 0;
   localparam int RSP_EVICTED_POS = 1;
   localparam int RSP_ADDR_LSB    = 2;
   localparam int RSP_DIRTY_POS   = RSP_ADDR_LSB + PAGE_BITS;
   localparam int RSP_BITS        = 40;

endpackage

[rtl/lru_page_buffer_tracker.sv]
// channel  | ports                                     | contents (lowest bit first)
// ---------+-------------------------------------------+--------------------------------------
// request  | req_tvalid/req_tready/req_tdata/req_tuser | tdata: page_address; tuser: cmd
// response | rsp_tvalid/rsp_tready/rsp_tdata           | hit, evicted, evicted_address, evicted_dirty
// control  | csr_we/csr_wdata                          | resident_limit
//
// each request is handled from acceptance to the response by a scan and a table update:
// one tag/stamp ram entry per cycle through a single compare unit, each behind its
// registered read; a new request is taken only once the previous one has left the update
// synchronous reset clears valid and dirty flags, resident count and access counter, limit 8
// req_tready is low while a request is in progress; the update cycle waits while the
// response register still holds a result that has not been taken
module lru_page_buffer_tracker #(
   parameter int ENTRIES    = lpbt_pkg::LPBT_ENTRIES,
   parameter int ADDR_BITS  = lpbt_pkg::LPBT_ADDR_BITS,
   parameter int STAMP_BITS = lpbt_pkg::LPBT_STAMP_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lpbt_pkg::PAGE_BITS-1:0]  req_tdata,   // page_address
   input  logic [0:0]                      req_tuser,   // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit, evicted, evicted_address, evicted_dirty, zero fill
   output logic [lpbt_pkg::RSP_BITS-1:0]   rsp_tdata,
   input  logic                            csr_we,
   input  logic [lpbt_pkg::LIMIT_BITS-1:0] csr_wdata
);

   import lpbt_pkg::*;

   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);
   localparam int CMP_BITS   = CNT_BITS + LIMIT_BITS;
   localparam int ENTRY_BITS = STAMP_BITS + ADDR_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   state_type                state_ff, state_in;
   logic [LIMIT_BITS-1:0]    limit_ff, limit_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [STAMP_BITS-1:0]    counter_ff, counter_in;
   logic [ENTRIES-1:0]       valid_ff, valid_in;
   logic [ENTRIES-1:0]       dirty_ff, dirty_in;
   logic [CNT_BITS-1:0]      scan_ff, scan_in;
   logic [ADDR_BITS-1:0]     addr_ff, addr_in;
   logic                     wr_ff, wr_in;

   logic                     hit_found_ff, hit_found_in;
   logic [IDX_BITS-1:0]      hit_idx_ff, hit_idx_in;
   logic                     free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]      free_idx_ff, free_idx_in;
   logic                     lru_found_ff, lru_found_in;
   logic [IDX_BITS-1:0]      lru_idx_ff, lru_idx_in;
   logic [STAMP_BITS-1:0]    lru_stamp_ff, lru_stamp_in;
   logic [ADDR_BITS-1:0]     lru_tag_ff, lru_tag_in;
   logic                     lru_dirty_ff, lru_dirty_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic                     rsp_evicted_ff, rsp_evicted_in;
   logic [PAGE_BITS-1:0]     rsp_addr_ff, rsp_addr_in;
   logic                     rsp_dirty_ff, rsp_dirty_in;

   logic                     ram_wr_en;
   logic [IDX_BITS-1:0]      ram_wr_addr;
   logic                     ram_rd_en;
   logic [ENTRY_BITS-1:0]    ram_rd_data;

   logic [CNT_BITS-1:0]      proc_cnt;
   logic [IDX_BITS-1:0]      proc_idx;
   logic                     proc_en;
   logic [ADDR_BITS-1:0]     ent_tag;
   logic [STAMP_BITS-1:0]    ent_stamp;
   logic                     ent_valid;
   logic                     ent_older;
   logic                     new_older;
   logic                     over_limit;
   logic                     out_free;
   logic                     req_fire;

   // tag and stamp storage, one entry read per scan cycle
   lpbt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({counter_ff, addr_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_ff[IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   // entry whose ram data arrives this cycle
   assign proc_cnt  = scan_ff - CNT_BITS'(1);
   assign proc_idx  = proc_cnt[IDX_BITS-1:0];
   assign proc_en   = (state_ff == ST_SCAN) && (scan_ff != '0);
   assign ram_rd_en = (state_ff == ST_SCAN) && (scan_ff < CNT_BITS'(ENTRIES));
   assign ent_tag   = ram_rd_data[ADDR_BITS-1:0];
   assign ent_stamp = ram_rd_data[ENTRY_BITS-1:ADDR_BITS];
   assign ent_valid = valid_ff[proc_idx];

   // stamp compares: older stamp wins, equal stamps go to the lower address
   assign ent_older = !lru_found_ff || (ent_stamp < lru_stamp_ff) ||
                      ((ent_stamp == lru_stamp_ff) && (ent_tag < lru_tag_ff));
   assign new_older = !lru_found_ff || (counter_ff < lru_stamp_ff) ||
                      ((counter_ff == lru_stamp_ff) && (addr_ff < lru_tag_ff));

   assign over_limit = (CMP_BITS'(count_ff) + CMP_BITS'(1)) > CMP_BITS'(limit_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      count_in      = count_ff;
      counter_in    = counter_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      scan_in       = scan_ff;
      addr_in       = addr_ff;
      wr_in         = wr_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      lru_found_in  = lru_found_ff;
      lru_idx_in    = lru_idx_ff;
      lru_stamp_in  = lru_stamp_ff;
      lru_tag_in    = lru_tag_ff;
      lru_dirty_in  = lru_dirty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_dirty_in  = rsp_dirty_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = lru_idx_ff;

      if (csr_we) begin
         limit_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_in       = ADDR_BITS'(req_tdata);
               wr_in         = (req_tuser[0] == CMD_WRITE);
               counter_in    = counter_ff + STAMP_BITS'(1);
               scan_in       = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               lru_found_in  = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            scan_in = scan_ff + CNT_BITS'(1);
            if (proc_en) begin
               // first resident match
               if (ent_valid && (ent_tag == addr_ff) && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = proc_idx;
               end
               // first free entry
               if (!ent_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = proc_idx;
               end
               // least recently used resident entry
               if (ent_valid && ent_older) begin
                  lru_found_in = 1'b1;
                  lru_idx_in   = proc_idx;
                  lru_stamp_in = ent_stamp;
                  lru_tag_in   = ent_tag;
                  lru_dirty_in = dirty_ff[proc_idx];
               end
            end
            if (scan_ff == CNT_BITS'(ENTRIES)) begin
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = 1'b0;
               rsp_evicted_in = 1'b0;
               rsp_addr_in    = '0;
               rsp_dirty_in   = 1'b0;
               state_in       = ST_IDLE;
               priority if (hit_found_ff) begin
                  // refresh stamp, write access sets dirty
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = hit_idx_ff;
                  dirty_in[hit_idx_ff] = dirty_ff[hit_idx_ff] | wr_ff;
                  rsp_hit_in           = 1'b1;
               end else if (free_found_ff) begin
                  if (!over_limit) begin
                     // fill a free entry
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     dirty_in[free_idx_ff] = wr_ff;
                     count_in              = count_ff + CNT_BITS'(1);
                  end else if (new_older) begin
                     // the new page itself is oldest and leaves at once
                     rsp_evicted_in = 1'b1;
                     rsp_addr_in    = PAGE_BITS'(addr_ff);
                     rsp_dirty_in   = wr_ff;
                  end else begin
                     // fill free entry and drop the oldest resident page
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     dirty_in[free_idx_ff] = wr_ff;
                     valid_in[lru_idx_ff]  = 1'b0;
                     dirty_in[lru_idx_ff]  = 1'b0;
                     rsp_evicted_in        = 1'b1;
                     rsp_addr_in           = PAGE_BITS'(lru_tag_ff);
                     rsp_dirty_in          = lru_dirty_ff;
                  end
               end else begin
                  // table full: the oldest page gives up its entry
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = lru_idx_ff;
                  dirty_in[lru_idx_ff] = wr_ff;
                  rsp_evicted_in       = 1'b1;
                  rsp_addr_in          = PAGE_BITS'(lru_tag_ff);
                  rsp_dirty_in         = lru_dirty_ff;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         counter_ff   <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         counter_ff   <= counter_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff        <= scan_in;
      addr_ff        <= addr_in;
      wr_ff          <= wr_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      lru_found_ff   <= lru_found_in;
      lru_idx_ff     <= lru_idx_in;
      lru_stamp_ff   <= lru_stamp_in;
      lru_tag_ff     <= lru_tag_in;
      lru_dirty_ff   <= lru_dirty_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_dirty_ff   <= rsp_dirty_in;
   end

   // response packing
   assign rsp_tvalid = rsp_valid_ff;
   always_comb begin
      rsp_tdata                                         = '0;
      rsp_tdata[RSP_HIT_POS]                            = rsp_hit_ff;
      rsp_tdata[RSP_EVICTED_POS]                        = rsp_evicted_ff;
      rsp_tdata[RSP_ADDR_LSB +: PAGE_BITS]              = rsp_addr_ff;
      rsp_tdata[RSP_DIRTY_POS]                          = rsp_dirty_ff;
   end

endmodule

[rtl/lpbt_ram.sv]
module lpbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lpbt_checker.sv]
module lpbt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lpbt_pkg::RSP_BITS-1:0]   rsp_tdata
);

   import lpbt_pkg::*;

   logic rsp_hit;
   logic rsp_evicted;
   logic rsp_dirty;
   logic no_evict_data;

   assign rsp_hit       = rsp_tdata[RSP_HIT_POS];
   assign rsp_evicted   = rsp_tdata[RSP_EVICTED_POS];
   assign rsp_dirty     = rsp_tdata[RSP_DIRTY_POS];
   assign no_evict_data = (rsp_tdata[RSP_ADDR_LSB +: PAGE_BITS] == '0) && !rsp_dirty;

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_hit && rsp_evicted))
      else $error("hit response also reports an eviction");

   // eviction fields are zero when nothing was evicted
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_evicted) |-> no_evict_data)
      else $error("eviction fields set without an eviction");

   // a request keeps the block busy for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted on two consecutive cycles");

   // a new response only follows a busy period
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared without a request in progress");

   // response register is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind lru_page_buffer_tracker lpbt_checker u_lpbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/lpbt_page_checker.sv]
`timescale 1ns / 100ps

module lpbt_page_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lpbt_pkg::PAGE_BITS-1:0]  req_tdata,   // page_address
   input  logic [0:0]                      req_tuser,   // cmd
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit, evicted, evicted_address, evicted_dirty, zero fill
   input  logic [lpbt_pkg::RSP_BITS-1:0]   rsp_tdata,
   input  logic                            csr_we,
   input  logic [lpbt_pkg::LIMIT_BITS-1:0] csr_wdata,
   output int                              error_count,
   output int                              pending,
   output int                              hit_count,
   output int                              evict_count,
   output int                              writeback_count
);

   import lpbt_pkg::*;

   typedef struct packed {
      logic                 hit;
      logic                 evicted;
      logic [PAGE_BITS-1:0] victim_addr;
      logic                 victim_dirty;
   } page_outcome_type;

   // shadow of the page table
   logic [PAGE_BITS-1:0]       page_tag   [LPBT_ENTRIES];
   logic                       page_live  [LPBT_ENTRIES];
   logic [LPBT_STAMP_BITS-1:0] page_stamp [LPBT_ENTRIES];
   logic                       page_dirty [LPBT_ENTRIES];
   int                         live_pages;
   logic [LPBT_STAMP_BITS-1:0] access_clock;
   logic [LIMIT_BITS-1:0]      page_limit;

   // outcomes predicted for accepted requests, oldest first
   page_outcome_type outcome_q[$];

   // live entry with the smallest stamp, ties to the lower address; ENTRIES if none
   function automatic int oldest_page();
      int best;
      best = LPBT_ENTRIES;
      for (int i = 0; i < LPBT_ENTRIES; i++) begin
         if (page_live[i]) begin
            if (best == LPBT_ENTRIES || page_stamp[i] < page_stamp[best] ||
                (page_stamp[i] == page_stamp[best] && page_tag[i] < page_tag[best])) begin
               best = i;
            end
         end
      end
      return best;
   endfunction

   // apply one access to the shadow table and return its response
   function automatic page_outcome_type track_access(input logic is_write,
                                                     input logic [PAGE_BITS-1:0] addr);
      page_outcome_type o;
      int               slot;
      int               victim;
      o = '0;
      slot = -1;
      access_clock = access_clock + 1'b1;

      // lookup
      for (int i = 0; i < LPBT_ENTRIES; i++) begin
         if (slot < 0 && page_live[i] && page_tag[i] == addr) begin
            slot = i;
         end
      end
      if (slot >= 0) begin
         page_stamp[slot] = access_clock;
         if (is_write) begin
            page_dirty[slot] = 1'b1;
         end
         o.hit = 1'b1;
         return o;
      end

      // miss: take a free entry, or free the least recently used one
      for (int i = 0; i < LPBT_ENTRIES; i++) begin
         if (slot < 0 && !page_live[i]) begin
            slot = i;
         end
      end
      if (slot < 0) begin
         victim = oldest_page();
         if (victim >= LPBT_ENTRIES) begin
            victim = 0;
         end
         o.evicted      = 1'b1;
         o.victim_addr  = page_tag[victim];
         o.victim_dirty = page_dirty[victim];
         page_live[victim] = 1'b0;
         if (live_pages > 0) begin
            live_pages--;
         end
         slot = victim;
      end
      page_tag[slot]   = addr;
      page_live[slot]  = 1'b1;
      page_stamp[slot] = access_clock;
      page_dirty[slot] = is_write;
      live_pages++;

      // over the limit: drop the least recently used page, possibly the new one
      if (!o.evicted && live_pages > int'(page_limit)) begin
         victim = oldest_page();
         if (victim < LPBT_ENTRIES) begin
            o.evicted      = 1'b1;
            o.victim_addr  = page_tag[victim];
            o.victim_dirty = page_dirty[victim];
            page_live[victim]  = 1'b0;
            page_dirty[victim] = 1'b0;
            live_pages--;
         end
      end
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [PAGE_BITS-1:0] want,
                                       input logic [PAGE_BITS-1:0] got);
      if (got !== want) begin
         $error("rsp %s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin : monitor
      page_outcome_type want;
      if (reset) begin
         for (int i = 0; i < LPBT_ENTRIES; i++) begin
            page_live[i]  = 1'b0;
            page_dirty[i] = 1'b0;
         end
         live_pages      = 0;
         access_clock    = '0;
         page_limit      = LIMIT_RESET;
         outcome_q.delete();
         error_count     = 0;
         hit_count       = 0;
         evict_count     = 0;
         writeback_count = 0;
      end else begin
         if (csr_we) begin
            page_limit = csr_wdata;
         end
         // responses first: one taken at the same edge belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("rsp with no request outstanding: tdata 0x%0h", rsp_tdata);
               error_count++;
            end else begin
               want = outcome_q.pop_front();
               check_field("hit", PAGE_BITS'(want.hit),
                           PAGE_BITS'(rsp_tdata[RSP_HIT_POS]));
               check_field("evicted", PAGE_BITS'(want.evicted),
                           PAGE_BITS'(rsp_tdata[RSP_EVICTED_POS]));
               check_field("evicted_address", want.victim_addr,
                           rsp_tdata[RSP_ADDR_LSB +: PAGE_BITS]);
               check_field("evicted_dirty", PAGE_BITS'(want.victim_dirty),
                           PAGE_BITS'(rsp_tdata[RSP_DIRTY_POS]));
               hit_count       += int'(want.hit);
               evict_count     += int'(want.evicted);
               writeback_count += int'(want.victim_dirty);
            end
         end
         if (req_tvalid && req_tready) begin
            outcome_q.insert(outcome_q.size(), track_access(req_tuser[0], req_tdata));
         end
      end
      pending = outcome_q.size();
   end

endmodule

[tb/sv/tb_lru_page_buffer_tracker.sv]
`timescale 1ns / 100ps

module tb_lru_page_buffer_tracker;
   import lpbt_pkg::*;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 212;
   localparam int POOL_MAX    = 24;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PAGE_BITS-1:0]  req_tdata  = '0;
   logic [0:0]            req_tuser  = CMD_READ;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [LIMIT_BITS-1:0] csr_wdata  = '0;

   int error_count;
   int pending;
   int hit_count;
   int evict_count;
   int writeback_count;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;
   int limit_writes   = 0;

   logic [PAGE_BITS-1:0] page_pool [POOL_MAX];
   int                   pool_size;

   lru_page_buffer_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   lpbt_page_checker u_page_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending         (pending),
      .hit_count       (hit_count),
      .evict_count     (evict_count),
      .writeback_count (writeback_count)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // run limit
   initial begin
      #2000000;
      $display("tb_lru_page_buffer_tracker: done, errors");
      $finish;
   end

   // present one request, with a random gap first, and wait for it to be taken
   task automatic send_access(input logic is_write, input logic [PAGE_BITS-1:0] addr);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tuser  <= is_write;
      do @(negedge clock); while (req_tready !== 1'b1);
      @(posedge clock);
      items_sent++;
   endtask

   // stop sending until every predicted response is back and the block is ready
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0 || req_tready !== 1'b1);
      @(posedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_BITS-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      limit_writes++;
   endtask

   // random accesses drawn mostly from a small page pool so hits and evictions mix
   task automatic run_phase(input logic [LIMIT_BITS-1:0] value, input int mode);
      logic [PAGE_BITS-1:0] addr;
      int                   pick;
      send_idle_pct  = (mode == 1) ? 78 : (mode == 3) ? 37 : 0;
      recv_stall_pct = (mode == 2) ? 78 : (mode == 3) ? 37 : 0;
      set_limit(value);
      pool_size = $urandom_range(2, POOL_MAX);
      for (int k = 0; k < pool_size; k++) begin
         if (k > 0 && $urandom_range(3) == 0) begin
            page_pool[k] = page_pool[k-1] + 1'b1;
         end else begin
            page_pool[k] = $urandom;
         end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == PHASE_ITEMS / 2) begin
            wait_drained();
         end
         pick = $urandom_range(99);
         if (pick < 82) begin
            addr = page_pool[$urandom_range(pool_size - 1)];
         end else if (pick < 88) begin
            addr = $urandom_range(1) ? '1 : '0;
         end else begin
            addr = $urandom;
         end
         send_access($urandom_range(1) ? CMD_WRITE : CMD_READ, addr);
      end
   endtask

   initial begin : stimulus
      logic [LIMIT_BITS-1:0] phase_limit [PHASES];
      phase_limit = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd12, 4'd3, 4'd0};
      phase_limit[PHASES-1] = LIMIT_BITS'($urandom_range(15));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // limit zero on an empty table: the new page evicts itself
      set_limit(4'd0);
      send_access(CMD_WRITE, 32'hFFFF_FFFF);
      send_access(CMD_READ, 32'h0000_0000);

      // extreme addresses, hits on both, then fill past the top limit
      set_limit(4'd15);
      send_access(CMD_WRITE, 32'h0000_0000);
      send_access(CMD_READ, 32'hFFFF_FFFF);
      send_access(CMD_READ, 32'h0000_0000);
      send_access(CMD_WRITE, 32'hFFFF_FFFF);
      for (int b = 0; b < 14; b++) begin
         send_access(b[0] ? CMD_WRITE : CMD_READ, 32'h1 << b);
      end

      // limit lowered under the resident count: one eviction per miss, none on hits
      set_limit(4'd2);
      send_access(CMD_READ, 32'hA5A5_5A5A);
      send_access(CMD_READ, 32'hA5A5_5A5A);
      send_access(CMD_WRITE, 32'h8000_0000);

      for (int p = 0; p < PHASES; p++) begin
         run_phase(phase_limit[p], p % 4);
      end

      wait_drained();
      repeat (40) @(posedge clock);

      $display("covered %0d requests over %0d limit settings, four idle patterns",
               items_sent, limit_writes);
      $display("responses seen: %0d hits, %0d evictions, %0d needing write-back",
               hit_count, evict_count, writeback_count);
      if (error_count == 0) begin
         $display("tb_lru_page_buffer_tracker: done, clean");
      end else begin
         $display("tb_lru_page_buffer_tracker: done, errors");
      end
      $finish;
   end

endmodule

[lru_page_buffer_tracker.f]
rtl/lpbt_pkg.sv
rtl/lpbt_ram.sv
rtl/lru_page_buffer_tracker.sv
rtl/lpbt_checker.sv
tb/sv/lpbt_page_checker.sv
tb/sv/tb_lru_page_buffer_tracker.sv
